### hdl/melt_zone_thermal_observer_macros.svh
// assertion macros for the melt zone thermal observer
`ifndef MELT_ZONE_THERMAL_OBSERVER_MACROS_SVH
`define MELT_ZONE_THERMAL_OBSERVER_MACROS_SVH

// checked only outside reset
`define MZTO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in reset too
`define MZTO_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mzto_pkg.sv
// shared types, constants and helpers of the melt zone thermal observer
package mzto_pkg;

  localparam int AW = 34;   // multiplier a operand
  localparam int BW = 48;   // multiplier b operand, three digits
  localparam int ACCW = AW + BW;
  localparam int RW = 52;   // rate accumulators
  localparam int DW = 50;   // deltas before saturation

  localparam logic signed [31:0] T_RESET = 32'sd1638400;
  localparam logic signed [19:0] INLET_RESET = 20'sd1600;
  localparam logic [16:0] DUTY_FULL = 17'd65536;
  localparam logic signed [47:0] RATE_LIMIT = 48'sh7FFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    REG_HEATER_DRIVE = 3'd0,
    REG_HS_HEATER    = 3'd1,
    REG_HS_SENSOR    = 3'd2,
    REG_SM_SENSOR    = 3'd3,
    REG_SM_MELT      = 3'd4,
    REG_ENTHALPY     = 3'd5,
    REG_INLET        = 3'd6,
    REG_GAINS        = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_FINISH
  } state_t;

  // program steps of one item
  typedef enum logic [3:0] {
    P_DRIVE   = 4'd0,
    P_FLOWK   = 4'd1,
    P_HS_H    = 4'd2,
    P_HS_S    = 4'd3,
    P_SM_S    = 4'd4,
    P_SM_M    = 4'd5,
    P_ENTH    = 4'd6,
    P_ADV_H   = 4'd7,
    P_ADV_S   = 4'd8,
    P_ADV_M   = 4'd9,
    P_GDT_H   = 4'd10,
    P_COR_H   = 4'd11,
    P_GDT_S   = 4'd12,
    P_COR_S   = 4'd13,
    P_GDT_M   = 4'd14,
    P_COR_M   = 4'd15
  } step_t;

  typedef struct packed {
    logic                  start;
    logic signed [AW-1:0]  a;
    logic signed [BW-1:0]  b;
  } mac_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [ACCW-1:0] acc;
  } mac_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [DW-1:0] v);
    logic signed [31:0] r;
    if (v > 50'sh0_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -50'sh0_0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [BW-1:0] clamp_rate(input logic signed [RW-1:0] v);
    logic signed [BW-1:0] r;
    if (v > RW'(RATE_LIMIT)) r = RATE_LIMIT;
    else if (v < -RW'(RATE_LIMIT)) r = -RATE_LIMIT;
    else r = v[BW-1:0];
    return r;
  endfunction

endpackage

### hdl/mzto_in_if.sv
// request channel carrying one observer step
interface mzto_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [16:0]        heater_duty;
  logic signed [15:0] flow_rate;
  logic signed [19:0] measured_temp;
  logic [15:0]        time_step;

  modport source (output valid, op, heater_duty, flow_rate, measured_temp, time_step,
                  input ready);
  modport sink (input valid, op, heater_duty, flow_rate, measured_temp, time_step,
                output ready);
endinterface

### hdl/mzto_out_if.sv
// result channel carrying the three estimates
interface mzto_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] heater_temp;
  logic signed [31:0] sensor_temp;
  logic signed [31:0] melt_temp;

  modport source (output valid, heater_temp, sensor_temp, melt_temp, input ready);
  modport sink (input valid, heater_temp, sensor_temp, melt_temp, output ready);
endinterface

### hdl/melt_zone_thermal_observer.sv
// top level of the melt zone thermal observer
// One request with a nonzero time step advances the heater, sensor and melt estimates
// by one Euler step and, with op set, applies the observer correction; a zero time
// step leaves the estimates unchanged. One result carrying the three estimates
// follows every request. All products run through a single 34 x 17 bit multiplier,
// one digit of the b operand at a time over three digits, each product with its
// own issue and write-back. The block takes no new request until the current one
// has been handed to the result register.
module melt_zone_thermal_observer (
  input  logic         clk,
  input  logic         rst_n,
  mzto_in_if.sink      in_ch,
  mzto_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_wdata
);
  import mzto_pkg::*;

  `include "melt_zone_thermal_observer_macros.svh"

  // configuration
  logic [31:0]        drive_coef_r, hs_h_r, hs_s_r, sm_s_r, sm_m_r, enth_r;
  logic signed [19:0] inlet_r;
  logic [47:0]        gains_r;

  // latched request
  logic               op_r;
  logic [16:0]        duty_r;
  logic [14:0]        flow_r;
  logic signed [19:0] meas_r;
  logic [15:0]        dt_r;

  // estimates and intermediates
  logic signed [31:0]   th_r, ts_r, tm_r;
  logic signed [RW-1:0] rh_r, rs_r, rm_r;
  logic [39:0]          k_r;
  logic signed [31:0]   gdt_r;
  logic signed [AW-1:0] innov_r;

  logic               out_valid_r;
  logic signed [31:0] out_h_r, out_s_r, out_m_r;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   accept, load_out;
  logic   mac_start;

  mac_req_t req;
  mac_rsp_t rsp;

  logic signed [AW-1:0] d_hs, d_sm, d_in, innov;
  logic signed [RW-1:0] p24;
  logic signed [DW-1:0] dlt16, dlt24;

  mzto_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_coef_r <= '0;
      hs_h_r       <= '0;
      hs_s_r       <= '0;
      sm_s_r       <= '0;
      sm_m_r       <= '0;
      enth_r       <= '0;
      inlet_r      <= INLET_RESET;
      gains_r      <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_HEATER_DRIVE: drive_coef_r <= cfg_wdata[31:0];
        REG_HS_HEATER:    hs_h_r       <= cfg_wdata[31:0];
        REG_HS_SENSOR:    hs_s_r       <= cfg_wdata[31:0];
        REG_SM_SENSOR:    sm_s_r       <= cfg_wdata[31:0];
        REG_SM_MELT:      sm_m_r       <= cfg_wdata[31:0];
        REG_ENTHALPY:     enth_r       <= cfg_wdata[31:0];
        REG_INLET:        inlet_r      <= $signed(cfg_wdata[19:0]);
        REG_GAINS:        gains_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_ch.op;
      duty_r <= (in_ch.heater_duty > DUTY_FULL) ? DUTY_FULL : in_ch.heater_duty;
      flow_r <= in_ch.flow_rate[15] ? 15'd0 : in_ch.flow_rate[14:0];
      meas_r <= in_ch.measured_temp;
      dt_r   <= in_ch.time_step;
    end
  end

  // operands from the state before the step; innovation after the prediction
  assign d_hs  = AW'(th_r) - AW'(ts_r);
  assign d_sm  = AW'(ts_r) - AW'(tm_r);
  assign d_in  = AW'(tm_r) - (AW'(inlet_r) <<< 10);
  assign innov = (AW'(meas_r) <<< 10) - AW'(ts_r);

  always_comb begin
    req.start = mac_start;
    req.a = '0;
    req.b = '0;
    case (step_r)
      P_DRIVE: begin
        req.a = AW'($signed({1'b0, drive_coef_r}));
        req.b = BW'($signed({1'b0, duty_r}));
      end
      P_FLOWK: begin
        req.a = AW'($signed({1'b0, enth_r}));
        req.b = BW'($signed({1'b0, flow_r}));
      end
      P_HS_H: begin req.a = d_hs; req.b = BW'($signed({1'b0, hs_h_r})); end
      P_HS_S: begin req.a = d_hs; req.b = BW'($signed({1'b0, hs_s_r})); end
      P_SM_S: begin req.a = d_sm; req.b = BW'($signed({1'b0, sm_s_r})); end
      P_SM_M: begin req.a = d_sm; req.b = BW'($signed({1'b0, sm_m_r})); end
      P_ENTH: begin req.a = d_in; req.b = BW'($signed({1'b0, k_r})); end
      P_ADV_H: begin req.a = AW'($signed({1'b0, dt_r})); req.b = clamp_rate(rh_r); end
      P_ADV_S: begin req.a = AW'($signed({1'b0, dt_r})); req.b = clamp_rate(rs_r); end
      P_ADV_M: begin req.a = AW'($signed({1'b0, dt_r})); req.b = clamp_rate(rm_r); end
      P_GDT_H: begin
        req.a = AW'($signed(gains_r[15:0]));
        req.b = BW'($signed({1'b0, dt_r}));
      end
      P_GDT_S: begin
        req.a = AW'($signed(gains_r[31:16]));
        req.b = BW'($signed({1'b0, dt_r}));
      end
      P_GDT_M: begin
        req.a = AW'($signed(gains_r[47:32]));
        req.b = BW'($signed({1'b0, dt_r}));
      end
      P_COR_H, P_COR_S, P_COR_M: begin req.a = innov_r; req.b = BW'(gdt_r); end
      default: ;
    endcase
  end

  assign p24   = RW'(rsp.acc >>> 24);
  assign dlt16 = DW'(rsp.acc >>> 16);
  assign dlt24 = DW'(rsp.acc >>> 24);

  // write-back of each product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th_r <= T_RESET;
      ts_r <= T_RESET;
      tm_r <= T_RESET;
    end else if (state_r == S_WAIT && rsp.done) begin
      case (step_r)
        P_DRIVE: rh_r <= RW'(dlt16);
        P_FLOWK: k_r  <= rsp.acc[47:8];
        P_HS_H:  rh_r <= rh_r - p24;
        P_HS_S:  rs_r <= p24;
        P_SM_S:  rs_r <= rs_r - p24;
        P_SM_M:  rm_r <= p24;
        P_ENTH:  rm_r <= rm_r - p24;
        P_ADV_H: th_r <= sat32(DW'(th_r) + dlt16);
        P_ADV_S: ts_r <= sat32(DW'(ts_r) + dlt16);
        P_ADV_M: tm_r <= sat32(DW'(tm_r) + dlt16);
        // innovation is frozen once the prediction is done
        P_GDT_H: begin
          gdt_r   <= rsp.acc[31:0];
          innov_r <= innov;
        end
        P_GDT_S, P_GDT_M: gdt_r <= rsp.acc[31:0];
        P_COR_H: th_r <= sat32(DW'(th_r) + dlt24);
        P_COR_S: ts_r <= sat32(DW'(ts_r) + dlt24);
        P_COR_M: tm_r <= sat32(DW'(tm_r) + dlt24);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= P_DRIVE;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    mac_start   = 1'b0;
    load_out    = 1'b0;
    in_ch.ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          step_nxt  = P_DRIVE;
          state_nxt = (in_ch.time_step == 16'd0) ? S_FINISH : S_ISSUE;
        end
      end
      S_ISSUE: begin
        mac_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (rsp.done) begin
          if (step_r == P_COR_M || (step_r == P_ADV_M && !op_r)) begin
            state_nxt = S_FINISH;
          end else begin
            step_nxt  = step_t'(step_r + 4'd1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_h_r <= th_r;
      out_s_r <= ts_r;
      out_m_r <= tm_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.heater_temp = out_h_r;
  assign out_ch.sensor_temp = out_s_r;
  assign out_ch.melt_temp   = out_m_r;

  `MZTO_ASSERT(a_accept_starts, accept |=> state_r != S_IDLE, "request accepted but sequencer idle")
  `MZTO_ASSERT(a_done_in_wait, rsp.done |-> state_r == S_WAIT, "product finished outside wait")
  `MZTO_ASSERT(a_corr_needs_op, (state_r == S_ISSUE && step_r > P_ADV_M) |-> op_r, "correction without op")
  `MZTO_ASSERT_RST(a_reset_idle, !rst_n |=> state_r == S_IDLE, "sequencer not idle after reset")

endmodule

### hdl/mzto_mac.sv
// digit-serial signed multiplier, 34 x 17 bits a cycle over three digits
module mzto_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  mzto_pkg::mac_req_t req,
  output mzto_pkg::mac_rsp_t rsp
);
  import mzto_pkg::*;

  logic signed [AW-1:0]   a_r;
  logic signed [BW-1:0]   b_r;
  logic signed [ACCW-1:0] acc_r;
  logic [1:0]             dig_r;
  logic                   busy_r;
  logic                   done_r;
  logic signed [16:0]     dig_val;
  logic signed [AW+16:0]  prod;
  logic signed [ACCW-1:0] addend;

  always_comb begin
    case (dig_r)
      2'd0: dig_val = $signed({1'b0, b_r[15:0]});
      2'd1: dig_val = $signed({1'b0, b_r[31:16]});
      2'd2: dig_val = $signed({b_r[47], b_r[47:32]});
      default: dig_val = '0;
    endcase
  end

  assign prod = a_r * dig_val;

  always_comb begin
    case (dig_r)
      2'd0: addend = ACCW'(prod);
      2'd1: addend = ACCW'(prod) <<< 16;
      2'd2: addend = ACCW'(prod) <<< 32;
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      dig_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        dig_r  <= '0;
      end else if (busy_r) begin
        dig_r <= dig_r + 2'd1;
        if (dig_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + addend;
    end
  end

  assign rsp.done = done_r;
  assign rsp.acc  = acc_r;

endmodule
